/* src/ed_pkg.sv */
// ----------------------------------------------------------------------------
// ed_pkg
// Shared types and constants for the edit distance block.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam logic ACT_REF   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int unsigned    DIST_W   = 7;
  localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Control bits of the wavefront token that moves along the cell chain.
  typedef struct packed {
    logic valid;
    logic upd;
  } tok_ctrl_t;

endpackage

/* src/edit_distance.sv */
// ----------------------------------------------------------------------------
// edit_distance
// Levenshtein distance between a loaded reference string and a streamed
// query string, computed on a chain of MAX_LEN cells.
// ----------------------------------------------------------------------------
// A reference item never holds the input. Each query item launches a
// wavefront token that walks the chain of MAX_LEN cells, one cell per cycle,
// and the input is held until the token has left the chain. A query item with
// the last mark produces one result when its token leaves the chain, and the
// block then returns to an empty pair. Input items keep flowing while a
// result waits, except a further last query item.
module edit_distance #(
  parameter int MAX_LEN    = 64,
  parameter int CHAR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        action,
  input  logic [15:0] char_code,
  input  logic        has_char,
  input  logic        last,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [ed_pkg::DIST_W-1:0] distance,
  output logic        overflow
);

  localparam int DW = $clog2(MAX_LEN + 1);

  ed_pkg::state_t    state;
  ed_pkg::state_t    state_next;
  logic [DW-1:0]     ref_len;
  logic [DW-1:0]     qlen;
  logic              ovf;
  logic              run_last;

  logic              accept;
  logic              ref_acc;
  logic              qry_acc;
  logic              ref_room;
  logic              qry_room;
  logic              ld_en;
  logic              done;
  logic              finish;
  logic [CHAR_WIDTH-1:0] ch;
  logic [DW-1:0]     qlen_inc;
  logic [31:0]       res_ext;

  ed_pkg::tok_ctrl_t     t_ctrl [0:MAX_LEN];
  logic [CHAR_WIDTH-1:0] t_ch   [0:MAX_LEN];
  logic [DW-1:0]         t_left [0:MAX_LEN];
  logic [DW-1:0]         t_diag [0:MAX_LEN];
  logic [DW-1:0]         t_res  [0:MAX_LEN];

  assign ch       = CHAR_WIDTH'(char_code);
  assign accept   = item_valid && item_ready;
  assign ref_acc  = accept && (action == ed_pkg::ACT_REF);
  assign qry_acc  = accept && (action == ed_pkg::ACT_QUERY);
  assign ref_room = ref_len < DW'(MAX_LEN);
  assign qry_room = qlen < DW'(MAX_LEN);
  assign ld_en    = ref_acc && has_char && (qlen == '0) && ref_room;
  assign qlen_inc = DW'(qlen + 1'b1);
  assign done     = t_ctrl[MAX_LEN].valid;
  assign finish   = done && run_last;
  assign res_ext  = 32'(t_res[MAX_LEN]);

  always_comb begin
    state_next = state;
    case (state)
      ed_pkg::ST_IDLE: begin
        if (qry_acc) begin
          state_next = ed_pkg::ST_RUN;
        end
      end
      ed_pkg::ST_RUN: begin
        if (done) begin
          state_next = ed_pkg::ST_IDLE;
        end
      end
      default: state_next = ed_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ed_pkg::ST_IDLE: begin
        item_ready = !(result_valid && item_valid &&
                       (action == ed_pkg::ACT_QUERY) && last);
      end
      default: item_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ed_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      ref_len <= '0;
      qlen    <= '0;
      ovf     <= 1'b0;
    end else begin
      if (ld_en) begin
        ref_len <= DW'(ref_len + 1'b1);
      end
      if (ref_acc && has_char && (qlen == '0) && !ref_room) begin
        ovf <= 1'b1;
      end
      if (qry_acc && has_char) begin
        if (qry_room) begin
          qlen <= qlen_inc;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_ctrl[0].valid <= 1'b0;
      t_ctrl[0].upd   <= 1'b0;
      run_last        <= 1'b0;
    end else begin
      t_ctrl[0].valid <= qry_acc;
      t_ctrl[0].upd   <= qry_acc && has_char && qry_room;
      if (qry_acc) begin
        run_last <= last;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_ch[0]   <= ch;
    t_diag[0] <= qlen;
    if (has_char && qry_room) begin
      t_left[0] <= qlen_inc;
      t_res[0]  <= qlen_inc;
    end else begin
      t_left[0] <= qlen;
      t_res[0]  <= qlen;
    end
  end

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    ed_cell #(
      .IDX (k),
      .DW  (DW),
      .CW  (CHAR_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (finish),
      .ld_en     (ld_en),
      .ld_char   (ch),
      .ref_len   (ref_len),
      .tin       (t_ctrl[k-1]),
      .tin_ch    (t_ch[k-1]),
      .tin_left  (t_left[k-1]),
      .tin_diag  (t_diag[k-1]),
      .tin_res   (t_res[k-1]),
      .tout      (t_ctrl[k]),
      .tout_ch   (t_ch[k]),
      .tout_left (t_left[k]),
      .tout_diag (t_diag[k]),
      .tout_res  (t_res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      distance <= (res_ext > 32'(ed_pkg::DIST_MAX)) ? ed_pkg::DIST_MAX
                                                     : res_ext[ed_pkg::DIST_W-1:0];
      overflow <= ovf;
    end
  end

endmodule

/* src/ed_cell.sv */
// ----------------------------------------------------------------------------
// ed_cell
// One column of the distance table: holds one reference character and one
// table entry, updates the entry when the wavefront token passes and hands
// the token to the next cell.
// ----------------------------------------------------------------------------
module ed_cell #(
  parameter int IDX = 1,
  parameter int DW  = 7,
  parameter int CW  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              ld_en,
  input  logic [CW-1:0]     ld_char,
  input  logic [DW-1:0]     ref_len,
  input  ed_pkg::tok_ctrl_t tin,
  input  logic [CW-1:0]     tin_ch,
  input  logic [DW-1:0]     tin_left,
  input  logic [DW-1:0]     tin_diag,
  input  logic [DW-1:0]     tin_res,
  output ed_pkg::tok_ctrl_t tout,
  output logic [CW-1:0]     tout_ch,
  output logic [DW-1:0]     tout_left,
  output logic [DW-1:0]     tout_diag,
  output logic [DW-1:0]     tout_res
);

  logic [DW-1:0] dp;
  logic [CW-1:0] rch;
  logic          active;
  logic          upd_here;
  logic          cost;
  logic [DW:0]   up1;
  logic [DW:0]   left1;
  logic [DW:0]   diag1;
  logic [DW:0]   min_ab;
  logic [DW:0]   min_abc;
  logic [DW-1:0] dp_new;

  assign active   = DW'(IDX) <= ref_len;
  assign upd_here = tin.valid && tin.upd && active;
  assign cost     = rch != tin_ch;
  assign up1      = {1'b0, dp} + 1'b1;
  assign left1    = {1'b0, tin_left} + 1'b1;
  assign diag1    = {1'b0, tin_diag} + {{DW{1'b0}}, cost};
  assign min_ab   = (up1 < left1) ? up1 : left1;
  assign min_abc  = (min_ab < diag1) ? min_ab : diag1;
  assign dp_new   = upd_here ? min_abc[DW-1:0] : dp;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      dp <= DW'(IDX);
    end else if (upd_here) begin
      dp <= dp_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en && (ref_len == DW'(IDX - 1))) begin
      rch <= ld_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
      tout.upd   <= 1'b0;
    end else begin
      tout <= tin;
    end
  end

  always_ff @(posedge clk) begin
    tout_ch   <= tin_ch;
    tout_left <= dp_new;
    tout_diag <= dp;
    tout_res  <= (ref_len == DW'(IDX)) ? dp_new : tin_res;
  end

endmodule

/* src/ed_checker.sv */
// ----------------------------------------------------------------------------
// ed_checker
// Port-level checks of the edit distance block, bound to the top level.
// ----------------------------------------------------------------------------
module ed_checker #(
  parameter int MAX_LEN = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        action,
  input logic        last,
  input logic        result_valid,
  input logic        result_ready,
  input logic [ed_pkg::DIST_W-1:0] distance,
  input logic        overflow
);

  logic qry_acc;
  logic ref_acc;

  assign qry_acc = item_valid && item_ready && (action == ed_pkg::ACT_QUERY);
  assign ref_acc = item_valid && item_ready && (action == ed_pkg::ACT_REF);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(distance) && $stable(overflow))
    else $error("Result changed while stalled.");

  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(distance) <= 32'(MAX_LEN)))
    else $error("Distance exceeds the longest string.");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    qry_acc |=> !item_ready)
    else $error("Input taken while a query item is in the chain.");

  a_result_after_query: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("Result appeared without a query item in flight.");

  a_ref_single_cycle: assert property (@(posedge clk) disable iff (rst)
    ref_acc |=> item_ready ||
      (item_valid && (action == ed_pkg::ACT_QUERY) && last && result_valid))
    else $error("Reference item stalled the input.");

endmodule

bind edit_distance ed_checker #(.MAX_LEN(MAX_LEN)) u_ed_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .action       (action),
  .last         (last),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .distance     (distance),
  .overflow     (overflow)
);

/* tb/ed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_scoreboard
// Watches both channels of the edit distance block, keeps its own copy of
// the reference string and the distance row, and compares each result with
// the oldest predicted distance and overflow flag.
// ----------------------------------------------------------------------------
module ed_scoreboard #(
  parameter int MAX_LEN    = 64,
  parameter int CHAR_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic        action,
  input  logic [15:0] char_code,
  input  logic        has_char,
  input  logic        last,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [ed_pkg::DIST_W-1:0] distance,
  input  logic        overflow,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);

  typedef struct packed {
    logic [ed_pkg::DIST_W-1:0] dist_val;
    logic                      ovf;
  } score_t;

  logic [CHAR_WIDTH-1:0] ref_str [MAX_LEN];
  logic [LEN_W-1:0]      ref_len;
  logic [LEN_W-1:0]      qry_len;
  logic [LEN_W-1:0]      row [MAX_LEN+1];
  logic                  trunc;
  score_t                scores_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic void clear_pair();
    ref_len = '0;
    qry_len = '0;
    trunc   = 1'b0;
    for (int j = 0; j <= MAX_LEN; j++) begin
      row[j] = LEN_W'(j);
    end
  endfunction

  task automatic score_item(input logic act, input logic [15:0] code,
                            input logic hc, input logic lst);
    logic [CHAR_WIDTH-1:0] c;
    logic [LEN_W:0]        diag;
    logic [LEN_W:0]        up;
    logic [LEN_W:0]        best;
    logic [LEN_W:0]        sub;
    score_t                s;
    c = CHAR_WIDTH'(code);
    if (act == ed_pkg::ACT_REF) begin
      if (qry_len == 0 && hc) begin
        if (ref_len < MAX_LEN) begin
          ref_str[ref_len] = c;
          ref_len = ref_len + 1'b1;
        end else begin
          trunc = 1'b1;
        end
      end
    end else begin
      if (hc) begin
        if (qry_len < MAX_LEN) begin
          diag = row[0];
          qry_len = qry_len + 1'b1;
          row[0] = qry_len;
          for (int j = 1; j <= ref_len; j++) begin
            up   = row[j];
            best = up + 1'b1;
            if (row[j-1] + 1 < best) begin
              best = row[j-1] + 1'b1;
            end
            sub = diag + (ref_str[j-1] != c);
            if (sub < best) begin
              best = sub;
            end
            row[j] = best[LEN_W-1:0];
            diag = up;
          end
        end else begin
          trunc = 1'b1;
        end
      end
      if (lst) begin
        s.dist_val = (row[ref_len] > ed_pkg::DIST_MAX) ? ed_pkg::DIST_MAX
                                                        : ed_pkg::DIST_W'(row[ref_len]);
        s.ovf      = trunc;
        scores_due.push_back(s);
        clear_pair();
      end
    end
  endtask

  always @(posedge clk) begin
    score_t want;
    if (rst) begin
      clear_pair();
      scores_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        checked++;
        if (scores_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got distance %0d overflow %0b",
                   $time, distance, overflow);
        end else begin
          want = scores_due.pop_front();
          if (distance !== want.dist_val) begin
            fail_count++;
            $display("%0t: distance mismatch, expected %0d, got %0d",
                     $time, want.dist_val, distance);
          end
          if (overflow !== want.ovf) begin
            fail_count++;
            $display("%0t: overflow mismatch, expected %0b, got %0b",
                     $time, want.ovf, overflow);
          end
        end
      end
      if (item_valid && item_ready) begin
        score_item(action, char_code, has_char, last);
      end
    end
    pending <= scores_due.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the edit distance block. Sends reference and query strings
// as bursts of items with random gaps, stalls the result side on its own
// pattern, and leaves prediction and comparison to the scoreboard.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_LEN    = 64;
  localparam int CHAR_WIDTH = 16;
  localparam int RANDOM_ITEMS = 1650;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic        action;
  logic [15:0] char_code;
  logic        has_char;
  logic        last;
  logic        result_valid;
  logic        result_ready;
  logic [ed_pkg::DIST_W-1:0] distance;
  logic        overflow;

  int          fail_count;
  int          pending;
  int          checked;
  int          items_sent;
  int          pairs_sent;
  int          burst_left;
  logic [15:0] pair_alphabet [3];

  edit_distance #(
    .MAX_LEN    (MAX_LEN),
    .CHAR_WIDTH (CHAR_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .char_code    (char_code),
    .has_char     (has_char),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .distance     (distance),
    .overflow     (overflow)
  );

  ed_scoreboard #(
    .MAX_LEN    (MAX_LEN),
    .CHAR_WIDTH (CHAR_WIDTH)
  ) u_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .char_code    (char_code),
    .has_char     (has_char),
    .last         (last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .distance     (distance),
    .overflow     (overflow),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[edit_distance] ERROR");
    $finish;
  end

  task automatic send_item(input logic act, input logic [15:0] code,
                           input logic hc, input logic lst);
    int gap;
    @(negedge clk);
    item_valid <= 1'b1;
    action     <= act;
    char_code  <= code;
    has_char   <= hc;
    last       <= lst;
    do @(posedge clk); while (!item_ready);
    items_sent++;
    burst_left = burst_left - 1;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
  endtask

  function automatic logic [15:0] pick_char();
    if ($urandom_range(0, 7) == 0) begin
      return 16'($urandom_range(0, 65535));
    end
    return pair_alphabet[$urandom_range(0, 2)];
  endfunction

  // Noise items (ignored reference items, empty query items) only go in
  // before the query's final item so that they never open the next pair.
  task automatic send_pair(input int rlen, input int qlen, input bit noisy);
    bit end_empty;
    for (int k = 0; k < 3; k++) begin
      pair_alphabet[k] = 16'($urandom_range(0, 65535));
    end
    if (rlen == 0 && $urandom_range(0, 1)) begin
      send_item(ed_pkg::ACT_REF, 16'($urandom_range(0, 65535)), 1'b0, 1'b1);
    end
    for (int i = 0; i < rlen; i++) begin
      if (noisy && $urandom_range(0, 5) == 0) begin
        send_item(ed_pkg::ACT_REF, 16'($urandom_range(0, 65535)), 1'b0,
                  1'($urandom_range(0, 1)));
      end
      send_item(ed_pkg::ACT_REF, pick_char(), 1'b1,
                (i == rlen - 1) || ($urandom_range(0, 7) == 0));
    end
    end_empty = (qlen == 0) || ($urandom_range(0, 4) == 0);
    for (int i = 0; i < qlen; i++) begin
      send_item(ed_pkg::ACT_QUERY, pick_char(), 1'b1, !end_empty && i == qlen - 1);
      if (noisy && (end_empty || i < qlen - 1)) begin
        if ($urandom_range(0, 3) == 0) begin
          send_item(ed_pkg::ACT_REF, pick_char(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 5) == 0) begin
          send_item(ed_pkg::ACT_QUERY, 16'($urandom_range(0, 65535)), 1'b0, 1'b0);
        end
      end
    end
    if (end_empty) begin
      send_item(ed_pkg::ACT_QUERY, 16'($urandom_range(0, 65535)), 1'b0, 1'b1);
    end
    pairs_sent++;
  endtask

  // Result side: switches between three stall modes at random, and once
  // holds off for a long stretch so that the block backs up into its input.
  initial begin
    int  rx_mode;
    int  rx_left;
    bit  held;
    result_ready = 1'b0;
    rx_mode = 0;
    rx_left = 0;
    held    = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && items_sent >= 200) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (600) @(negedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          default: result_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  initial begin
    int rlen;
    int qlen;
    int random_start;
    int p;
    rst        = 1'b1;
    item_valid = 1'b0;
    action     = ed_pkg::ACT_REF;
    char_code  = 16'h0000;
    has_char   = 1'b0;
    last       = 1'b0;
    items_sent = 0;
    pairs_sent = 0;
    burst_left = $urandom_range(1, 24);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Both strings empty.
    send_item(ed_pkg::ACT_QUERY, 16'h0000, 1'b0, 1'b1);
    // Extreme codes, last mark on the reference.
    send_item(ed_pkg::ACT_REF, 16'hFFFF, 1'b1, 1'b1);
    send_item(ed_pkg::ACT_QUERY, 16'h0000, 1'b1, 1'b1);
    // An empty reference item, a reference item after the query has started,
    // and empty query items, the last of which ends the query.
    send_item(ed_pkg::ACT_REF, 16'h0000, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_REF, 16'hFFFF, 1'b0, 1'b1);
    send_item(ed_pkg::ACT_QUERY, 16'h0000, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_REF, 16'h1234, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_QUERY, 16'hAAAA, 1'b0, 1'b0);
    send_item(ed_pkg::ACT_QUERY, 16'h0000, 1'b0, 1'b1);
    // Non-empty reference against an empty query.
    send_item(ed_pkg::ACT_REF, 16'h5555, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_REF, 16'hAAAA, 1'b1, 1'b1);
    send_item(ed_pkg::ACT_REF, 16'h5555, 1'b1, 1'b1);
    send_item(ed_pkg::ACT_QUERY, 16'hFFFF, 1'b0, 1'b1);
    // Swapped characters.
    send_item(ed_pkg::ACT_REF, 16'hAAAA, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_REF, 16'h5555, 1'b1, 1'b1);
    send_item(ed_pkg::ACT_QUERY, 16'h5555, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_QUERY, 16'hAAAA, 1'b1, 1'b1);
    // Query longer than the reference.
    send_item(ed_pkg::ACT_REF, 16'h0001, 1'b1, 1'b1);
    send_item(ed_pkg::ACT_QUERY, 16'h0001, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_QUERY, 16'h0002, 1'b1, 1'b0);
    send_item(ed_pkg::ACT_QUERY, 16'h0003, 1'b1, 1'b1);
    pairs_sent += 6;

    random_start = items_sent;
    p = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (p == 0) begin
        rlen = MAX_LEN + 6;
        qlen = $urandom_range(1, 5);
      end else if (p == 1) begin
        rlen = 3;
        qlen = MAX_LEN + 6;
      end else if (p == 2) begin
        rlen = MAX_LEN;
        qlen = MAX_LEN;
      end else if ($urandom_range(0, 19) == 0) begin
        rlen = $urandom_range(0, MAX_LEN + 6);
        qlen = $urandom_range(0, MAX_LEN + 6);
      end else begin
        rlen = $urandom_range(0, 10);
        qlen = $urandom_range(0, 10);
      end
      send_pair(rlen, qlen, $urandom_range(0, 4) == 0);
      p++;
    end

    @(negedge clk);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (MAX_LEN + 8) @(posedge clk);

    $display("Sent %0d items in %0d string pairs; %0d distances came back and were compared.",
             items_sent, pairs_sent, checked);
    if (fail_count == 0) begin
      $display("[edit_distance] OK");
    end else begin
      $display("[edit_distance] ERROR");
    end
    $finish;
  end

endmodule
